// ===== rtl/ancestry_tract_segmenter_unit_macros.svh =====
// Assertion macros for the ancestry tract segmenter unit.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef ANCESTRY_TRACT_SEGMENTER_UNIT_MACROS_SVH
`define ANCESTRY_TRACT_SEGMENTER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define ATS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ats_pkg.sv =====
// Shared types and constants for the ancestry tract segmenter.
// No dependencies.
package ats_pkg;

  localparam int unsigned SAMPLE_W        = 10;
  localparam int unsigned CHROM_W         = 8;
  localparam int unsigned POS_W           = 32;
  localparam int unsigned ANC_W           = 8;
  localparam int unsigned NUM_SAMPLES_DEF = 1024;

  localparam logic [ANC_W-1:0]   ANC_MISSING  = 8'd255;
  localparam logic [2*ANC_W-1:0] PAIR_MISSING = {ANC_MISSING, ANC_MISSING};

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_CLOSE   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_CHROM  = 2'd2
  } mode_t;

  typedef struct packed {
    op_t                 opcode;
    logic [SAMPLE_W-1:0] sample_index;
    logic                record_start;
    logic [CHROM_W-1:0]  chrom_id;
    logic [POS_W-1:0]    position;
    logic [ANC_W-1:0]    anc_hap0;
    logic [ANC_W-1:0]    anc_hap1;
  } in_beat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] tract_sample;
    logic [CHROM_W-1:0]  tract_chrom;
    logic [POS_W-1:0]    tract_start;
    logic [POS_W-1:0]    tract_end;
    logic [ANC_W-1:0]    tract_anc0;
    logic [ANC_W-1:0]    tract_anc1;
  } out_beat_t;

  typedef struct packed {
    logic [2*ANC_W-1:0] pair;
    logic [POS_W-1:0]   start;
  } entry_t;

  typedef struct packed {
    mode_t              mode;
    logic [CHROM_W-1:0] live_chrom;
    logic [CHROM_W-1:0] closing_chrom;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   mid;
  } rec_t;

endpackage

// ===== rtl/ats_mem.sv =====
// Per-sample open tract store: one write port, one registered read port.
// Depends on ats_pkg for the entry type.
module ats_mem #(
  parameter int unsigned DEPTH = ats_pkg::NUM_SAMPLES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ats_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output ats_pkg::entry_t rd_data
);

  ats_pkg::entry_t mem [DEPTH];
  ats_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ats_rec.sv =====
// Record tracker: latches record position, chromosome, midpoint and mode.
// Depends on ats_pkg for the record state and mode types.
module ats_rec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_start,
  input  logic [ats_pkg::CHROM_W-1:0]   chrom_id,
  input  logic [ats_pkg::POS_W-1:0]     position,
  output ats_pkg::rec_t                 rec
);

  ats_pkg::mode_t                mode_r, mode_nxt;
  logic [ats_pkg::CHROM_W-1:0]   chrom_r, chrom_nxt;
  logic [ats_pkg::CHROM_W-1:0]   closing_r, closing_nxt;
  logic [ats_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [ats_pkg::POS_W-1:0]     mid_r, mid_nxt;
  logic                          seen_r, seen_nxt;
  logic [ats_pkg::POS_W-1:0]     diff;

  assign diff = position - pos_r;

  always_comb begin
    mode_nxt    = mode_r;
    chrom_nxt   = chrom_r;
    closing_nxt = closing_r;
    pos_nxt     = pos_r;
    mid_nxt     = mid_r;
    seen_nxt    = seen_r;
    if (rec_start) begin
      pos_nxt = position;
      mid_nxt = pos_r + {1'b0, diff[ats_pkg::POS_W-1:1]};
      if (!seen_r) begin
        mode_nxt  = ats_pkg::MODE_FIRST;
        seen_nxt  = 1'b1;
        chrom_nxt = chrom_id;
      end else if (chrom_id != chrom_r) begin
        mode_nxt    = ats_pkg::MODE_CHROM;
        closing_nxt = chrom_r;
        chrom_nxt   = chrom_id;
      end else begin
        mode_nxt = ats_pkg::MODE_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ats_pkg::MODE_NORMAL;
      chrom_r   <= '0;
      closing_r <= '0;
      pos_r     <= '0;
      mid_r     <= '0;
      seen_r    <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      chrom_r   <= chrom_nxt;
      closing_r <= closing_nxt;
      pos_r     <= pos_nxt;
      mid_r     <= mid_nxt;
      seen_r    <= seen_nxt;
    end
  end

  assign rec.mode          = mode_r;
  assign rec.live_chrom    = chrom_r;
  assign rec.closing_chrom = closing_r;
  assign rec.cur_pos       = pos_r;
  assign rec.mid           = mid_r;

endmodule

// ===== rtl/ancestry_tract_segmenter_unit.sv =====
// Top level of the ancestry tract segmenter: accept, read-modify-write, result register.
// Depends on ats_pkg, ats_mem, ats_rec and the assertion macro header.
//
//  channel | direction | handshake           | beat
//  in_     | input     | in_valid / in_stall   | ats_pkg::in_beat_t
//  out_    | output    | out_valid / out_stall | ats_pkg::out_beat_t
//
// One beat per cycle while in_stall is low; the update stage feeds the result register.
// The tract store is read at acceptance and written back as the beat leaves the update
// stage; a back-to-back beat to the same sample takes the written entry by forwarding.
// After reset a sweep marks all min(NUM_SAMPLES, 1024) store entries missing; in_stall
// is high meanwhile.
// A held result stalls input only when the beat in the update stage also yields a result.
module ancestry_tract_segmenter_unit #(
  parameter int unsigned NUM_SAMPLES = ats_pkg::NUM_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ats_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_beat_t out_data
);

  localparam int unsigned MAX_IDX = 2 ** ats_pkg::SAMPLE_W;
  localparam int unsigned DEPTH   = (NUM_SAMPLES < MAX_IDX) ? NUM_SAMPLES : MAX_IDX;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ats_pkg::POS_W-1:0] POS_ONE = 1;

  logic                          in_acc;
  logic                          in_ok;
  logic [AW-1:0]                 in_addr;
  ats_pkg::rec_t                 rec;

  logic                          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;

  logic                          s1_valid_r, s1_valid_nxt;
  ats_pkg::op_t                  s1_op_r;
  logic [ats_pkg::SAMPLE_W-1:0]  s1_smp_r;
  logic [2*ats_pkg::ANC_W-1:0]   s1_pair_r;
  logic                          s1_ok_r;
  logic                          fwd_hit_r;
  ats_pkg::entry_t               fwd_data_r;

  ats_pkg::entry_t               rd_data;
  ats_pkg::entry_t               ent;
  ats_pkg::entry_t               upd_data;
  ats_pkg::out_beat_t            tract;
  logic                          s1_res;
  logic                          s1_wr;
  logic                          s1_adv;

  logic                          mem_wr_en;
  logic [AW-1:0]                 mem_wr_addr;
  ats_pkg::entry_t               mem_wr_data;

  logic                          out_valid_r, out_valid_nxt;
  ats_pkg::out_beat_t            out_data_r;

  assign in_ok   = 32'(in_data.sample_index) < 32'(NUM_SAMPLES);
  assign in_addr = in_data.sample_index[AW-1:0];

  // advance the update stage unless its result would overwrite a held beat
  assign s1_adv   = s1_valid_r && (!s1_res || !out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  ats_rec u_rec (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_start (in_acc && in_data.opcode == ats_pkg::OP_OBSERVE && in_data.record_start),
    .chrom_id  (in_data.chrom_id),
    .position  (in_data.position),
    .rec       (rec)
  );

  assign mem_wr_en   = clr_busy_r || (s1_adv && s1_wr);
  assign mem_wr_addr = clr_busy_r ? clr_addr_r : s1_smp_r[AW-1:0];
  assign mem_wr_data = clr_busy_r ?
                       ats_pkg::entry_t'{pair: ats_pkg::PAIR_MISSING, start: '0} : upd_data;

  ats_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    ent                = fwd_hit_r ? fwd_data_r : rd_data;
    s1_res             = 1'b0;
    s1_wr              = 1'b0;
    upd_data           = ent;
    tract.tract_sample = s1_smp_r;
    tract.tract_chrom  = rec.live_chrom;
    tract.tract_start  = ent.start;
    tract.tract_end    = rec.cur_pos;
    tract.tract_anc0   = ent.pair[2*ats_pkg::ANC_W-1:ats_pkg::ANC_W];
    tract.tract_anc1   = ent.pair[ats_pkg::ANC_W-1:0];
    if (s1_valid_r && s1_ok_r) begin
      unique case (s1_op_r)
        ats_pkg::OP_CLOSE: begin
          s1_res = ent.pair != ats_pkg::PAIR_MISSING;
        end
        ats_pkg::OP_OBSERVE: begin
          case (rec.mode)
            ats_pkg::MODE_FIRST: begin
              s1_wr          = 1'b1;
              upd_data.pair  = s1_pair_r;
              upd_data.start = rec.cur_pos;
            end
            ats_pkg::MODE_CHROM: begin
              s1_res            = ent.pair != ats_pkg::PAIR_MISSING;
              tract.tract_chrom = rec.closing_chrom;
              tract.tract_end   = rec.cur_pos - POS_ONE;
              s1_wr             = 1'b1;
              upd_data.pair     = s1_pair_r;
              upd_data.start    = rec.cur_pos;
            end
            ats_pkg::MODE_NORMAL: begin
              if (s1_pair_r != ent.pair) begin
                s1_res          = 1'b1;
                tract.tract_end = rec.mid;
                s1_wr           = 1'b1;
                upd_data.pair   = s1_pair_r;
                upd_data.start  = rec.mid + POS_ONE;
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && s1_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        fwd_hit_r <= s1_adv && s1_wr && (s1_smp_r[AW-1:0] == in_addr);
      end else if (s1_adv) begin
        fwd_hit_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_data.opcode;
      s1_smp_r   <= in_data.sample_index;
      s1_pair_r  <= {in_data.anc_hap0, in_data.anc_hap1};
      s1_ok_r    <= in_ok;
      fwd_data_r <= upd_data;
    end
    if (s1_adv && s1_res) begin
      out_data_r <= tract;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "ancestry_tract_segmenter_unit_macros.svh"

  `ATS_ASSERT_SAME(a_sweep_alone, clr_busy_r, !s1_valid_r && !out_valid_r, "beat in sweep")
  `ATS_ASSERT_SAME(a_fwd_live, fwd_hit_r, s1_valid_r, "forward hit with empty stage")
  `ATS_ASSERT_SAME(a_close_no_wr, s1_valid_r && s1_op_r == ats_pkg::OP_CLOSE, !s1_wr, "close write")
  `ATS_ASSERT_NEXT(a_sweep_once, !clr_busy_r, !clr_busy_r, "store sweep restarted")

endmodule
